### rtl/rde_pkg.sv
// Shared widths and sizes for the radix digit emitter.
package rde_pkg;

    // Field widths of the channels and the radix register
    localparam int VALUE_FIELD_W = 32;
    localparam int DIGIT_W       = 8;

    // Conversion width and digit stack size
    localparam int VALUE_W       = 32;
    localparam int STACK_DEPTH   = 32;

    localparam int STACK_ADDR_W  = $clog2(STACK_DEPTH);
    localparam int STACK_CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int DIV_CNT_W     = $clog2(VALUE_W);

    // Smallest usable radix; register values below it are raised to it
    localparam logic [DIGIT_W-1:0] RADIX_MIN   = DIGIT_W'(2);
    localparam logic [DIGIT_W-1:0] RADIX_RESET = DIGIT_W'(2);

endpackage

### rtl/rde_in_if.sv
// Input channel: one value item per handshake.
interface rde_in_if
    import rde_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [VALUE_FIELD_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

### rtl/rde_out_if.sv
// Output channel: one digit item per handshake.
interface rde_out_if
    import rde_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [DIGIT_W-1:0] digit;
    logic               last;

    modport source (output valid, output digit, output last, input ready);
    modport sink   (input valid, input digit, input last, output ready);
endinterface

### rtl/radix_digit_emitter_unit.sv
// Radix digit emitter: converts one value to digits of the configured radix, MSD first.
//
// Each value item is divided repeatedly by the radix in a shared bit-serial divider
// (each division is started in S_DIV_START, and its remainder is pushed onto the digit
// stack when it is done), and the stack is then popped through a registered-read RAM,
// each digit passing S_POP_RD, S_POP_WAIT and S_OUT, where it is held until the output
// side takes it. Zero gives the single digit 0. No new value is taken until the final
// digit, marked by last, has been delivered. The radix register may be written only
// between values; values 0 and 1 act as radix 2.
module radix_digit_emitter_unit
    import rde_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    rde_in_if.sink             value_ch,
    rde_out_if.source          digit_ch,
    input  logic               cfg_we,
    input  logic [DIGIT_W-1:0] cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_START,
        S_DIV_WAIT,
        S_POP_RD,
        S_POP_WAIT,
        S_OUT
    } state_t;

    state_t                 state_reg,   state_next;
    logic [DIGIT_W-1:0]     radix_reg;
    logic [DIGIT_W-1:0]     divisor_reg, divisor_next;
    logic [VALUE_W-1:0]     v_reg,       v_next;
    logic [STACK_CNT_W-1:0] depth_reg,   depth_next;
    logic [DIGIT_W-1:0]     digit_reg,   digit_next;
    logic                   last_reg,    last_next;
    logic                   valid_reg,   valid_next;

    logic                   div_start;
    logic                   div_done;
    logic [VALUE_W-1:0]     div_quot;
    logic [DIGIT_W-1:0]     div_rem;

    logic                   push;
    logic                   room;
    logic [STACK_CNT_W-1:0] pop_idx;
    logic [DIGIT_W-1:0]     stack_rdata;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (cfg_we)
        begin
            radix_reg <= cfg_wdata;
        end
    end

    // shared divider
    rde_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (v_reg),
        .divisor   (divisor_reg),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // digit stack
    assign room    = depth_reg < STACK_CNT_W'(STACK_DEPTH);
    assign push    = (state_reg == S_DIV_WAIT) && div_done && room;
    assign pop_idx = depth_reg - STACK_CNT_W'(1);

    rde_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (push),
        .waddr (depth_reg[STACK_ADDR_W-1:0]),
        .wdata (div_rem),
        .raddr (pop_idx[STACK_ADDR_W-1:0]),
        .rdata (stack_rdata)
    );

    assign div_start = (state_reg == S_DIV_START);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        divisor_next = divisor_reg;
        v_next       = v_reg;
        depth_next   = depth_reg;
        digit_next   = digit_reg;
        last_next    = last_reg;
        valid_next   = valid_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (value_ch.valid)
                begin
                    v_next       = VALUE_W'(value_ch.value);
                    divisor_next = (radix_reg < RADIX_MIN) ? RADIX_MIN : radix_reg;
                    depth_next   = '0;
                    state_next   = S_DIV_START;
                end
            end
            S_DIV_START:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    // remainders beyond the stack size are dropped
                    if (room)
                    begin
                        depth_next = depth_reg + STACK_CNT_W'(1);
                    end
                    v_next     = div_quot;
                    state_next = (div_quot == '0) ? S_POP_RD : S_DIV_START;
                end
            end
            S_POP_RD:
            begin
                depth_next = pop_idx;
                state_next = S_POP_WAIT;
            end
            S_POP_WAIT:
            begin
                digit_next = stack_rdata;
                last_next  = (depth_reg == '0);
                valid_next = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (digit_ch.ready)
                begin
                    valid_next = 1'b0;
                    state_next = last_reg ? S_IDLE : S_POP_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                valid_next = 1'b0;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            depth_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            valid_reg <= valid_next;
        end
    end

    // working value and output payload
    always_ff @(posedge clk)
    begin
        divisor_reg <= divisor_next;
        v_reg       <= v_next;
        digit_reg   <= digit_next;
        last_reg    <= last_next;
    end

    assign value_ch.ready = (state_reg == S_IDLE);
    assign digit_ch.valid = valid_reg;
    assign digit_ch.digit = digit_reg;
    assign digit_ch.last  = last_reg;

endmodule

### rtl/rde_ram.sv
// Generic single write port RAM with registered read.
module rde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/rde_div.sv
// Restoring divider: one quotient bit per cycle, narrow divisor.
module rde_div
    import rde_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [VALUE_W-1:0] dividend,
    input  logic [DIGIT_W-1:0] divisor,
    output logic               done,
    output logic [VALUE_W-1:0] quotient,
    output logic [DIGIT_W-1:0] remainder
);

    logic                 busy_reg,  busy_next;
    logic                 done_reg,  done_next;
    logic [DIV_CNT_W-1:0] cnt_reg,   cnt_next;
    logic [VALUE_W-1:0]   dd_reg,    dd_next;
    logic [DIGIT_W-1:0]   rem_reg,   rem_next;
    logic [DIGIT_W-1:0]   dvs_reg,   dvs_next;

    logic [DIGIT_W:0]     shifted;
    logic [DIGIT_W:0]     diff;
    logic                 ge;

    // one trial subtract per cycle
    assign shifted = {rem_reg, dd_reg[VALUE_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dd_next   = dd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dd_next   = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits the digit width
            rem_next = ge ? diff[DIGIT_W-1:0] : shifted[DIGIT_W-1:0];
            dd_next  = {dd_reg[VALUE_W-2:0], ge};
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(VALUE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        dd_reg  <= dd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = dd_reg;
    assign remainder = rem_reg;

endmodule
